FILE: rtl/v3alu_pkg.sv
package v3alu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQRT_STAGES   = 32;
  localparam int unsigned NUM_LANES     = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_LEN   = 3'd4,
    OP_NORM  = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic signed [63:0] prod;
    logic signed [63:0] cr_p;
    logic signed [63:0] cr_q;
    logic signed [31:0] lin;
    logic               lin_sat;
  } lane_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic [31:0]        len;
    res_t               res;
  } mid_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  function automatic sat_t clamp66(logic signed [65:0] v);
    sat_t r;
    if (v > 66'(S32_MAX)) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else if (v < 66'(S32_MIN)) begin
      r.val = S32_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/v3alu_lane.sv
module v3alu_lane (
  input  logic               clk_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] ap_i,
  input  logic signed [31:0] bp_i,
  input  logic signed [31:0] aq_i,
  input  logic signed [31:0] bq_i,
  output v3alu_pkg::lane_t   lane_o
);

  logic signed [31:0] rhs;
  logic signed [32:0] lin_sum;
  v3alu_pkg::sat_t    lin_c;
  v3alu_pkg::lane_t   lane_d, lane_q;

  always_comb begin
    rhs = (op_i == v3alu_pkg::OP_DOT) ? b_i : a_i;
    if (op_i == v3alu_pkg::OP_SUB) begin
      lin_sum = 33'(a_i) - 33'(b_i);
    end else begin
      lin_sum = 33'(a_i) + 33'(b_i);
    end
    lin_c          = v3alu_pkg::clamp66(66'(lin_sum));
    lane_d.prod    = 64'(a_i) * 64'(rhs);
    lane_d.cr_p    = 64'(ap_i) * 64'(bp_i);
    lane_d.cr_q    = 64'(aq_i) * 64'(bq_i);
    lane_d.lin     = lin_c.val;
    lane_d.lin_sat = lin_c.sat;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

FILE: rtl/v3alu_merge.sv
module v3alu_merge #(
  parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  v3alu_pkg::lane_t   lane_i [v3alu_pkg::NUM_LANES],
  output v3alu_pkg::mid_t    mid_o,
  output logic [63:0]        sq_o
);

  logic signed [65:0] dot_sum;
  logic signed [65:0] cr_d [v3alu_pkg::NUM_LANES];
  v3alu_pkg::sat_t    dot_c;
  v3alu_pkg::sat_t    cr_c [v3alu_pkg::NUM_LANES];
  v3alu_pkg::mid_t    mid_d, mid_q;
  logic [63:0]        sq_d, sq_q;

  always_comb begin
    dot_sum = 66'(lane_i[0].prod) + 66'(lane_i[1].prod) + 66'(lane_i[2].prod);
    dot_c   = v3alu_pkg::clamp66(dot_sum >>> FRAC_BITS);
    for (int i = 0; i < v3alu_pkg::NUM_LANES; i++) begin
      cr_d[i] = 66'(lane_i[i].cr_p) - 66'(lane_i[i].cr_q);
      cr_c[i] = v3alu_pkg::clamp66(cr_d[i] >>> FRAC_BITS);
    end
    sq_d = 64'(lane_i[0].prod) + 64'(lane_i[1].prod) + 64'(lane_i[2].prod);

    mid_d.op  = op_i;
    mid_d.a_x = a_x_i;
    mid_d.a_y = a_y_i;
    mid_d.a_z = a_z_i;
    mid_d.len = '0;
    mid_d.res = '0;
    case (op_i)
      v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB: begin
        mid_d.res.res_x     = lane_i[0].lin;
        mid_d.res.res_y     = lane_i[1].lin;
        mid_d.res.res_z     = lane_i[2].lin;
        mid_d.res.saturated = lane_i[0].lin_sat | lane_i[1].lin_sat | lane_i[2].lin_sat;
      end
      v3alu_pkg::OP_DOT: begin
        mid_d.res.res_scalar = dot_c.val;
        mid_d.res.saturated  = dot_c.sat;
      end
      v3alu_pkg::OP_CROSS: begin
        mid_d.res.res_x     = cr_c[0].val;
        mid_d.res.res_y     = cr_c[1].val;
        mid_d.res.res_z     = cr_c[2].val;
        mid_d.res.saturated = cr_c[0].sat | cr_c[1].sat | cr_c[2].sat;
      end
      default: begin
        mid_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    sq_q  <= sq_d;
  end

  assign mid_o = mid_q;
  assign sq_o  = sq_q;

endmodule

FILE: rtl/v3alu_sqrt.sv
module v3alu_sqrt (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  localparam int unsigned NS = v3alu_pkg::SQRT_STAGES;

  logic [63:0] rem_q  [NS];
  logic [31:0] root_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int unsigned B = NS - 1 - j;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = (66'(root_in) << (B + 1)) + (66'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if (66'(rem_in) >= trial) begin
        rem_q[j]  <= 64'(66'(rem_in) - trial);
        root_q[j] <= root_in | (32'd1 << B);
      end else begin
        rem_q[j]  <= rem_in;
        root_q[j] <= root_in;
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

FILE: rtl/v3alu_div_lane.sv
module v3alu_div_lane #(
  parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic [31:0]        len_i,
  output logic signed [31:0] quot_o
);

  localparam int unsigned DW = 32 + FRAC_BITS;
  localparam int unsigned QW = FRAC_BITS + 1;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic [31:0]   len_q [QW];
  logic          neg_q [QW];
  logic [31:0]   mag;
  logic [31:0]   qn;

  assign mag = a_i[31] ? 32'(-a_i) : 32'(a_i);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned K = QW - 1 - j;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [31:0]   len_in;
    logic          neg_in;
    logic [DW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = DW'(mag) << FRAC_BITS;
      assign q_in   = '0;
      assign len_in = len_i;
      assign neg_in = a_i[31];
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
      assign len_in = len_q[j-1];
      assign neg_in = neg_q[j-1];
    end

    assign trial = DW'(len_in) << K;

    always_ff @(posedge clk_i) begin
      len_q[j] <= len_in;
      neg_q[j] <= neg_in;
      if (rem_in >= trial) begin
        rem_q[j] <= rem_in - trial;
        q_q[j]   <= q_in | (QW'(1) << K);
      end else begin
        rem_q[j] <= rem_in;
        q_q[j]   <= q_in;
      end
    end
  end

  assign qn     = 32'(q_q[QW-1]);
  assign quot_o = neg_q[QW-1] ? -qn : qn;

endmodule

FILE: rtl/vec3_alu_unit.sv
// Three-component fixed-point vector ALU: add, subtract, dot, cross, length, normalise.
// A request passes the request, lane and merge registers, a delay chain beside the root pipeline and
// then the divider lanes, and the output register. Throughput is one word per cycle while busy is low; the 32-stage
// root pipeline and divider lanes are fully pipelined. busy is high during reset and until the first clock edge after
// it, then stays low. Reset clears ready and the valid chain only; the receiver cannot stall, so results are not held.
module vec3_alu_unit #(
  parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  v3alu_pkg::req_t   req_i,
  output v3alu_pkg::res_t   res_o,
  output logic              res_valid_o
);

  localparam int unsigned SQ  = v3alu_pkg::SQRT_STAGES;
  localparam int unsigned TOT = SQ + FRAC_BITS + 1;
  localparam int unsigned LAT = TOT + 4;

  logic               rdy_q;
  logic               acc;
  v3alu_pkg::req_t    req_q;
  logic               v_in_q, v_lane_q;
  logic [TOT:0]       vld_q;
  logic [2:0]         op1_q;
  logic signed [31:0] a1_q [3];
  logic signed [31:0] a_v [3];
  logic signed [31:0] b_v [3];
  v3alu_pkg::lane_t   lane_w [v3alu_pkg::NUM_LANES];
  v3alu_pkg::mid_t    mid_w;
  logic [63:0]        sq_w;
  logic [31:0]        root_w;
  v3alu_pkg::mid_t    pipe_q [1:TOT];
  logic signed [31:0] quot_w [3];
  logic signed [31:0] a_fin [3];
  v3alu_pkg::mid_t    fin;
  v3alu_pkg::res_t    res_d, res_q;
  logic               res_valid_q;
  logic [2:0]         out_op_q;

  assign acc  = start & rdy_q;
  assign busy = ~rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q       <= 1'b0;
      v_in_q      <= 1'b0;
      v_lane_q    <= 1'b0;
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      rdy_q       <= 1'b1;
      v_in_q      <= acc;
      v_lane_q    <= v_in_q;
      vld_q       <= {vld_q[TOT-1:0], v_lane_q};
      res_valid_q <= vld_q[TOT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= req_i;
    end
    op1_q    <= req_q.req_type;
    a1_q[0]  <= req_q.a_x;
    a1_q[1]  <= req_q.a_y;
    a1_q[2]  <= req_q.a_z;
    res_q    <= res_d;
    out_op_q <= fin.op;
  end

  assign a_v[0] = req_q.a_x;
  assign a_v[1] = req_q.a_y;
  assign a_v[2] = req_q.a_z;
  assign b_v[0] = req_q.b_x;
  assign b_v[1] = req_q.b_y;
  assign b_v[2] = req_q.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane u_lane (
      .clk_i  (clk_i),
      .op_i   (req_q.req_type),
      .a_i    (a_v[i]),
      .b_i    (b_v[i]),
      .ap_i   (a_v[(i+1)%3]),
      .bp_i   (b_v[(i+2)%3]),
      .aq_i   (a_v[(i+2)%3]),
      .bq_i   (b_v[(i+1)%3]),
      .lane_o (lane_w[i])
    );
  end

  v3alu_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .op_i   (op1_q),
    .a_x_i  (a1_q[0]),
    .a_y_i  (a1_q[1]),
    .a_z_i  (a1_q[2]),
    .lane_i (lane_w),
    .mid_o  (mid_w),
    .sq_o   (sq_w)
  );

  v3alu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .n_i    (sq_w),
    .root_o (root_w)
  );

  for (genvar k = 1; k <= TOT; k++) begin : g_pipe
    if (k == 1) begin : g_first
      always_ff @(posedge clk_i) begin
        pipe_q[k] <= mid_w;
      end
    end else if (k == SQ + 1) begin : g_len
      v3alu_pkg::mid_t stage_d;
      always_comb begin
        stage_d     = pipe_q[k-1];
        stage_d.len = root_w;
      end
      always_ff @(posedge clk_i) begin
        pipe_q[k] <= stage_d;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign a_fin[0] = pipe_q[SQ].a_x;
  assign a_fin[1] = pipe_q[SQ].a_y;
  assign a_fin[2] = pipe_q[SQ].a_z;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .a_i    (a_fin[i]),
      .len_i  (root_w),
      .quot_o (quot_w[i])
    );
  end

  assign fin = pipe_q[TOT];

  always_comb begin
    res_d = fin.res;
    case (fin.op)
      v3alu_pkg::OP_LEN: begin
        res_d            = '0;
        res_d.saturated  = fin.len[31];
        res_d.res_scalar = fin.len[31] ? v3alu_pkg::S32_MAX : $signed(fin.len);
      end
      v3alu_pkg::OP_NORM: begin
        res_d = '0;
        if (fin.len == '0) begin
          res_d.res_x = fin.a_x;
          res_d.res_y = fin.a_y;
          res_d.res_z = fin.a_z;
        end else begin
          res_d.res_x = quot_w[0];
          res_d.res_y = quot_w[1];
          res_d.res_z = quot_w[2];
        end
      end
      default: begin
        res_d = fin.res;
      end
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LAT))
    else $error("Result word without a matching request.");

  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT res_valid_o)
    else $error("Accepted request produced no result word.");

  a_norm_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_op_q == v3alu_pkg::OP_NORM) |-> !res_o.saturated)
    else $error("Normalise result flagged as saturated.");

  a_len_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_op_q == v3alu_pkg::OP_LEN) |->
      (res_o.res_x == '0 && res_o.res_y == '0 && res_o.res_z == '0 && !res_o.res_scalar[31]))
    else $error("Length result has a negative scalar or non-zero vector.");
`endif

endmodule

FILE: tb/sv/vec3_alu_checker.sv
`timescale 1ns / 100ps

module vec3_alu_checker #(
  parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  v3alu_pkg::req_t req_i,
  input  v3alu_pkg::res_t res_i,
  input  logic            res_valid_i,
  output int              fail_count_o,
  output int              pending_o
);
  import v3alu_pkg::*;

  res_t expected_results[$];
  int   fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();

  function automatic logic signed [31:0] clamp_s32(input logic signed [127:0] v,
                                                   inout logic sat);
    if (v > 128'(S32_MAX)) begin
      sat = 1'b1;
      return S32_MAX;
    end else if (v < 128'(S32_MIN)) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b    = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n    = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic res_t vector_result(input req_t r);
    res_t                res;
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] acc;
    logic signed [127:0] den;
    logic [63:0]         sq;
    logic [63:0]         len;
    logic                sat;
    res = '0;
    sat = 1'b0;
    a[0] = r.a_x; a[1] = r.a_y; a[2] = r.a_z;
    b[0] = r.b_x; b[1] = r.b_y; b[2] = r.b_z;
    case (r.req_type)
      OP_ADD, OP_SUB: begin
        res.res_x = clamp_s32(r.req_type == OP_ADD ? a[0] + b[0] : a[0] - b[0], sat);
        res.res_y = clamp_s32(r.req_type == OP_ADD ? a[1] + b[1] : a[1] - b[1], sat);
        res.res_z = clamp_s32(r.req_type == OP_ADD ? a[2] + b[2] : a[2] - b[2], sat);
      end
      OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.res_scalar = clamp_s32(acc >>> FRAC_BITS, sat);
      end
      OP_CROSS: begin
        res.res_x = clamp_s32((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, sat);
        res.res_y = clamp_s32((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, sat);
        res.res_z = clamp_s32((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, sat);
      end
      OP_LEN, OP_NORM: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        sq  = acc[63:0];
        len = floor_root(sq);
        den = $signed({64'd0, len});
        if (r.req_type == OP_LEN) begin
          res.res_scalar = clamp_s32(den, sat);
        end else if (len == 0) begin
          res.res_x = r.a_x;
          res.res_y = r.a_y;
          res.res_z = r.a_z;
        end else begin
          res.res_x = clamp_s32((a[0] <<< FRAC_BITS) / den, sat);
          res.res_y = clamp_s32((a[1] <<< FRAC_BITS) / den, sat);
          res.res_z = clamp_s32((a[2] <<< FRAC_BITS) / den, sat);
        end
      end
      default: begin
      end
    endcase
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_i) expected_results.push_back(vector_result(req_i));
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_i.res_x !== want.res_x) begin
          $error("res_x: expected %0d, got %0d", want.res_x, res_i.res_x);
          fail_count++;
        end
        if (res_i.res_y !== want.res_y) begin
          $error("res_y: expected %0d, got %0d", want.res_y, res_i.res_y);
          fail_count++;
        end
        if (res_i.res_z !== want.res_z) begin
          $error("res_z: expected %0d, got %0d", want.res_z, res_i.res_z);
          fail_count++;
        end
        if (res_i.res_scalar !== want.res_scalar) begin
          $error("res_scalar: expected %0d, got %0d", want.res_scalar, res_i.res_scalar);
          fail_count++;
        end
        if (res_i.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, res_i.saturated);
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import v3alu_pkg::*;

  localparam int unsigned LATENCY = 37 + FRAC_BITS_DEF;
  localparam int          ONE     = 1 << FRAC_BITS_DEF;

  logic clk_i = 1'b1;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  res_t res_o;
  logic res_valid_o;
  int   fail_count;
  int   pending;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  vec3_alu_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  vec3_alu_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .res_i       (res_o),
    .res_valid_i (res_valid_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  task automatic send_word(input req_t r);
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic req_t make_req(input logic [2:0] op, input logic signed [31:0] ax,
                                    input logic signed [31:0] ay, input logic signed [31:0] az,
                                    input logic signed [31:0] bx, input logic signed [31:0] by,
                                    input logic signed [31:0] bz);
    req_t r;
    r.req_type = op;
    r.a_x = ax; r.a_y = ay; r.a_z = az;
    r.b_x = bx; r.b_y = by; r.b_z = bz;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_component();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      3: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      4: begin
        case ($urandom_range(0, 5))
          0: return S32_MAX;
          1: return S32_MIN;
          2: return 0;
          3: return ONE;
          4: return -ONE;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  function automatic req_t rand_req();
    logic [2:0] op;
    op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    return make_req(op, rand_component(), rand_component(), rand_component(),
                    rand_component(), rand_component(), rand_component());
  endfunction

  initial begin
    op_e  op;
    int   n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    op = op.first();
    do begin
      send_word(make_req(op, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
      send_word(make_req(op, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
      op = op.next();
    end while (op != op.first());
    send_word(make_req(OP_CROSS, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN));
    send_word(make_req(OP_NORM, 0, 0, 0, 1, 2, 3));
    send_word(make_req(OP_NORM, ONE, 0, 0, 0, 0, 0));
    send_word(make_req(OP_NORM, -3, 4, 0, 0, 0, 0));
    send_word(make_req(OP_LEN, 0, 0, 0, 0, 0, 0));
    send_word(make_req(OP_DOT, -1, -1, -1, 1, 1, 1));
    send_word(make_req(OP_SUB, S32_MIN, 0, S32_MAX, 1, 0, -1));
    send_word(make_req(3'd6, S32_MAX, 1, 2, 3, 4, 5));
    send_word(make_req(3'd7, -1, -1, -1, -1, -1, -1));

    pause(0);
    while (pending != 0) @(posedge clk_i);

    n = 0;
    while (n < 1500) begin
      repeat ($urandom_range(1, 40)) begin
        send_word(rand_req());
        n++;
      end
      case ($urandom_range(0, 3))
        0: ;
        1: pause(1);
        2: pause($urandom_range(2, 8));
        default: pause($urandom_range(1, 3 * LATENCY / 2));
      endcase
    end
    pause(0);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
